### rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define VRT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds through reset.
`define VRT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VRT_ASSERT(lbl, clk, rstn, prop, msg)
`define VRT_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

### rtl/vrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vrt_pkg;

  // defaults for the top-level parameters
  localparam int unsigned AxisBitsDef = 5;
  localparam int unsigned FracBitsDef = 16;

  // direction is Q1.15, squared length Q.30, root Q.15
  localparam int unsigned DirW = 16;
  localparam int unsigned LsqW = 2 * DirW;
  localparam int unsigned LenW = DirW;

  // squared length at or below this counts as no direction
  localparam logic [LsqW-1:0] TinyLenSq = LsqW'(1073);

  // magnitude of a signed direction component
  function automatic logic [DirW-1:0] dir_mag(input logic signed [DirW-1:0] d);
    logic [DirW-1:0] m;
    m = d[DirW-1] ? (~d + DirW'(1)) : d;
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/voxel_ray_traversal.sv
// Write item: the occupancy row is read, updated and written back, then the
// result register is loaded. Cast item: squared length and, unless it is
// tiny, square root, per-axis setup on the shared serial divider and a walk
// with one occupancy-row read per step. One item at a time; the next is taken
// while a result waits. After reset a clearing pass over all 2^(2*AXIS_BITS)
// rows (1024 by default) empties the map before the first item is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module voxel_ray_traversal
  import vrt_pkg::*;
#(
  parameter int unsigned AXIS_BITS     = AxisBitsDef,
  parameter int unsigned FRACTION_BITS = FracBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [AXIS_BITS+FRACTION_BITS-1:0] cfg_data_i,
  // input items
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               op_i,
  input  wire logic [AXIS_BITS-1:0]               voxel_x_i,
  input  wire logic [AXIS_BITS-1:0]               voxel_y_i,
  input  wire logic [AXIS_BITS-1:0]               voxel_z_i,
  input  wire logic                               voxel_solid_i,
  input  wire logic [AXIS_BITS+FRACTION_BITS-1:0] origin_x_i,
  input  wire logic [AXIS_BITS+FRACTION_BITS-1:0] origin_y_i,
  input  wire logic [AXIS_BITS+FRACTION_BITS-1:0] origin_z_i,
  input  wire logic signed [DirW-1:0]             dir_x_i,
  input  wire logic signed [DirW-1:0]             dir_y_i,
  input  wire logic signed [DirW-1:0]             dir_z_i,
  // result items
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    hit_o,
  output logic [AXIS_BITS-1:0]                    break_x_o,
  output logic [AXIS_BITS-1:0]                    break_y_o,
  output logic [AXIS_BITS-1:0]                    break_z_o,
  output logic [AXIS_BITS-1:0]                    place_x_o,
  output logic [AXIS_BITS-1:0]                    place_y_o,
  output logic [AXIS_BITS-1:0]                    place_z_o
);

  localparam int unsigned PosW  = AXIS_BITS + FRACTION_BITS;
  localparam int unsigned CrdW  = AXIS_BITS + 2;
  localparam int unsigned RowW  = 2 * AXIS_BITS;
  localparam int unsigned Rows  = 1 << RowW;
  localparam int unsigned Side  = 1 << AXIS_BITS;
  localparam int unsigned DistW = 8 + FRACTION_BITS;
  localparam int unsigned OneW  = FRACTION_BITS + 1;
  localparam int unsigned NumW  = OneW + LenW;

  localparam logic [DistW-1:0] DistMax      = '1;
  localparam logic [PosW-1:0]  MaxReachRst  = PosW'(64'd8 << FRACTION_BITS);
  localparam logic [OneW-1:0]  OneQ         = OneW'(1) << FRACTION_BITS;

  // sequencer codes
  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_WR_RD   = 4'd2;
  localparam logic [3:0] S_WR_WB   = 4'd3;
  localparam logic [3:0] S_LEN     = 4'd4;
  localparam logic [3:0] S_CHK     = 4'd5;
  localparam logic [3:0] S_SQRT    = 4'd6;
  localparam logic [3:0] S_AX      = 4'd7;
  localparam logic [3:0] S_DT_GO   = 4'd8;
  localparam logic [3:0] S_DT_WAIT = 4'd9;
  localparam logic [3:0] S_TM_GO   = 4'd10;
  localparam logic [3:0] S_TM_WAIT = 4'd11;
  localparam logic [3:0] S_WK_RD   = 4'd12;
  localparam logic [3:0] S_WK_CHK  = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  logic [3:0]      state_q, state_d;
  logic [RowW-1:0] clr_q, clr_d;
  logic [1:0]      ax_q, ax_d;
  logic [PosW-1:0] max_reach_q;

  // item registers
  logic                   vox_solid_q;
  logic [AXIS_BITS-1:0]   vox_x_q, vox_y_q, vox_z_q;
  logic [PosW-1:0]        org_q [3];
  logic signed [DirW-1:0] dir_q [3];
  logic [LsqW-1:0]        lsq_q, lsq_d;
  logic [LenW-1:0]        len_q, len_d;
  logic [NumW-1:0]        prod_q, prod_d;

  // walk state
  logic [DistW-1:0]       tmax_q [3];
  logic [DistW-1:0]       tdelta_q [3];
  logic signed [CrdW-1:0] step_q [3];
  logic signed [CrdW-1:0] cur_q [3];
  logic signed [CrdW-1:0] prev_q [3];
  logic [DistW-1:0]       trav_q;

  // pending result
  logic                 res_hit_q, res_hit_d;
  logic [AXIS_BITS-1:0] res_brk_q [3];
  logic [AXIS_BITS-1:0] res_plc_q [3];

  // output register
  logic                 out_valid_q, out_valid_d;
  logic                 out_hit_q;
  logic [AXIS_BITS-1:0] out_brk_q [3];
  logic [AXIS_BITS-1:0] out_plc_q [3];

  // occupancy memory, one row of x bits per (z, y)
  logic [Side-1:0] occ_mem [Rows];
  logic [Side-1:0] rd_data_q;
  logic [RowW-1:0] mem_raddr, mem_waddr;
  logic [Side-1:0] mem_wdata;
  logic            mem_we;

  logic                   in_acc, out_load;
  logic signed [DirW-1:0] d_cur;
  logic [DirW-1:0]        mag_cur;
  logic signed [LsqW-1:0] sq_cur;
  logic [OneW-1:0]        dist_cur;
  logic [FRACTION_BITS-1:0] frac_cur;
  logic                   sq_start, sq_done;
  logic [LenW-1:0]        sq_root;
  logic                   div_start, div_done;
  logic [NumW-1:0]        div_num, div_quot;
  logic [DistW-1:0]       div_sat;
  logic [RowW-1:0]        wr_row, wk_row;
  logic [Side-1:0]        wr_data;
  logic                   in_win, solid_here, past_reach;
  logic [1:0]             sel;
  logic [DistW:0]         tsum;
  logic [DistW-1:0]       tsum_sat;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // per-axis setup operands
  assign d_cur    = dir_q[ax_q];
  assign mag_cur  = dir_mag(d_cur);
  assign sq_cur   = d_cur * d_cur;
  assign frac_cur = org_q[ax_q][FRACTION_BITS-1:0];
  assign dist_cur = d_cur[DirW-1] ? {1'b0, frac_cur} : (OneQ - {1'b0, frac_cur});

  // serial units
  assign sq_start  = (state_q == S_CHK) && (lsq_q > TinyLenSq);
  assign div_start = (state_q == S_DT_GO) || (state_q == S_TM_GO);
  assign div_num   = (state_q == S_DT_GO) ? NumW'({len_q, {FRACTION_BITS{1'b0}}}) : prod_q;
  assign div_sat   = (|div_quot[NumW-1:DistW]) ? DistMax : div_quot[DistW-1:0];

  vrt_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (lsq_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  vrt_div #(
    .NumW (NumW),
    .DenW (DirW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (mag_cur),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // walk: window test, memory lookup, smallest-tMax choice
  assign in_win = (cur_q[0][CrdW-1 -: 2] == 2'b00) && (cur_q[1][CrdW-1 -: 2] == 2'b00) &&
                  (cur_q[2][CrdW-1 -: 2] == 2'b00);
  assign wk_row     = {cur_q[2][AXIS_BITS-1:0], cur_q[1][AXIS_BITS-1:0]};
  assign wr_row     = {vox_z_q, vox_y_q};
  assign solid_here = in_win && rd_data_q[cur_q[0][AXIS_BITS-1:0]];
  assign past_reach = trav_q > DistW'(max_reach_q);

  always_comb begin
    priority if (tmax_q[0] <= tmax_q[1] && tmax_q[0] <= tmax_q[2]) begin
      sel = 2'd0;
    end else if (tmax_q[1] <= tmax_q[2]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  assign tsum     = {1'b0, tmax_q[sel]} + {1'b0, tdelta_q[sel]};
  assign tsum_sat = tsum[DistW] ? DistMax : tsum[DistW-1:0];

  // memory port control
  always_comb begin
    wr_data          = rd_data_q;
    wr_data[vox_x_q] = vox_solid_q;
    mem_raddr        = (state_q == S_WR_RD) ? wr_row : wk_row;
    mem_we           = (state_q == S_CLR) || (state_q == S_WR_WB);
    mem_waddr        = (state_q == S_CLR) ? clr_q : wr_row;
    mem_wdata        = (state_q == S_CLR) ? '0 : wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      occ_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= occ_mem[mem_raddr];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    ax_d      = ax_q;
    lsq_d     = lsq_q;
    len_d     = len_q;
    prod_d    = prod_q;
    res_hit_d = res_hit_q;
    unique case (state_q)
      S_CLR: begin
        clr_d = clr_q + RowW'(1);
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          res_hit_d = 1'b0;
          lsq_d     = '0;
          ax_d      = '0;
          state_d   = op_i ? S_LEN : S_WR_RD;
        end
      end
      S_WR_RD: state_d = S_WR_WB;
      S_WR_WB: state_d = S_DONE;
      S_LEN: begin
        lsq_d = lsq_q + LsqW'(unsigned'(sq_cur));
        if (ax_q == 2'd2) begin
          ax_d    = '0;
          state_d = S_CHK;
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      S_CHK: state_d = (lsq_q > TinyLenSq) ? S_SQRT : S_DONE;
      S_SQRT: begin
        if (sq_done) begin
          len_d   = sq_root;
          state_d = S_AX;
        end
      end
      S_AX: begin
        prod_d = NumW'(dist_cur) * NumW'(len_q);
        if (d_cur != '0) begin
          state_d = S_DT_GO;
        end else if (ax_q == 2'd2) begin
          state_d = S_WK_RD;
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      S_DT_GO:   state_d = S_DT_WAIT;
      S_DT_WAIT: if (div_done) state_d = S_TM_GO;
      S_TM_GO:   state_d = S_TM_WAIT;
      S_TM_WAIT: begin
        if (div_done) begin
          if (ax_q == 2'd2) begin
            state_d = S_WK_RD;
          end else begin
            ax_d    = ax_q + 2'd1;
            state_d = S_AX;
          end
        end
      end
      S_WK_RD: state_d = past_reach ? S_DONE : S_WK_CHK;
      S_WK_CHK: begin
        if (solid_here) begin
          res_hit_d = 1'b1;
          state_d   = S_DONE;
        end else begin
          state_d = S_WK_RD;
        end
      end
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      ax_q        <= '0;
      res_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      max_reach_q <= MaxReachRst;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ax_q        <= ax_d;
      res_hit_q   <= res_hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) max_reach_q <= cfg_data_i;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    lsq_q  <= lsq_d;
    len_q  <= len_d;
    prod_q <= prod_d;
    if (in_acc) begin
      vox_x_q     <= voxel_x_i;
      vox_y_q     <= voxel_y_i;
      vox_z_q     <= voxel_z_i;
      vox_solid_q <= voxel_solid_i;
      org_q[0]    <= origin_x_i;
      org_q[1]    <= origin_y_i;
      org_q[2]    <= origin_z_i;
      dir_q[0]    <= dir_x_i;
      dir_q[1]    <= dir_y_i;
      dir_q[2]    <= dir_z_i;
      cur_q[0]    <= CrdW'(origin_x_i[PosW-1:FRACTION_BITS]);
      cur_q[1]    <= CrdW'(origin_y_i[PosW-1:FRACTION_BITS]);
      cur_q[2]    <= CrdW'(origin_z_i[PosW-1:FRACTION_BITS]);
      prev_q[0]   <= CrdW'(origin_x_i[PosW-1:FRACTION_BITS]);
      prev_q[1]   <= CrdW'(origin_y_i[PosW-1:FRACTION_BITS]);
      prev_q[2]   <= CrdW'(origin_z_i[PosW-1:FRACTION_BITS]);
      trav_q      <= '0;
      for (int i = 0; i < 3; i++) begin
        res_brk_q[i] <= '0;
        res_plc_q[i] <= '0;
      end
    end
    // axis setup
    if (state_q == S_AX) begin
      if (d_cur == '0) begin
        tmax_q[ax_q]   <= DistMax;
        tdelta_q[ax_q] <= DistMax;
        step_q[ax_q]   <= '0;
      end else begin
        step_q[ax_q] <= d_cur[DirW-1] ? '1 : CrdW'(1);
      end
    end
    if (state_q == S_DT_WAIT && div_done) tdelta_q[ax_q] <= div_sat;
    if (state_q == S_TM_WAIT && div_done) tmax_q[ax_q]   <= div_sat;
    // walk step or hit capture
    if (state_q == S_WK_CHK) begin
      if (solid_here) begin
        for (int i = 0; i < 3; i++) begin
          res_brk_q[i] <= cur_q[i][AXIS_BITS-1:0];
          res_plc_q[i] <= prev_q[i][AXIS_BITS-1:0];
        end
      end else begin
        for (int i = 0; i < 3; i++) prev_q[i] <= cur_q[i];
        cur_q[sel]  <= cur_q[sel] + step_q[sel];
        trav_q      <= tmax_q[sel];
        tmax_q[sel] <= tsum_sat;
      end
    end
    if (out_load) begin
      out_hit_q <= res_hit_q;
      for (int i = 0; i < 3; i++) begin
        out_brk_q[i] <= res_brk_q[i];
        out_plc_q[i] <= res_plc_q[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign break_x_o   = out_brk_q[0];
  assign break_y_o   = out_brk_q[1];
  assign break_z_o   = out_brk_q[2];
  assign place_x_o   = out_plc_q[0];
  assign place_y_o   = out_plc_q[1];
  assign place_z_o   = out_plc_q[2];

  // checks
  `VRT_ASSERT(a_acc_leaves_idle, clk_i, rst_ni, in_acc |=> state_q != S_IDLE, "item not started")
  `VRT_ASSERT(a_load_free_slot, clk_i, rst_ni, out_load |-> !(out_valid_q && out_stall_i), "result overwritten")
  `VRT_ASSERT(a_div_in_wait, clk_i, rst_ni, div_done |-> (state_q == S_DT_WAIT || state_q == S_TM_WAIT), "stray quotient")

endmodule

`default_nettype wire

### rtl/vrt_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Integer square root, two radicand bits per cycle.
module vrt_isqrt
  import vrt_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [LsqW-1:0] val_i,
  output logic                 done_o,
  output logic [LenW-1:0]      root_o
);

  localparam int unsigned Iters = LsqW / 2;
  localparam int unsigned CntW  = $clog2(Iters + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [LsqW-1:0] val_q, val_d;
  logic [LenW+1:0] rem_q, rem_d;
  logic [LenW-1:0] root_q, root_d;
  logic [LenW+1:0] rem_sh, trial;

  // one digit: bring down two bits, try root*4+1
  always_comb begin
    rem_sh = {rem_q[LenW-1:0], val_q[LsqW-1 -: 2]};
    trial  = {root_q, 2'b01};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Iters);
      val_d  = val_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      val_d = {val_q[LsqW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[LenW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[LenW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

### rtl/vrt_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module vrt_div
  import vrt_pkg::*;
#(
  parameter int unsigned NumW = 33,
  parameter int unsigned DenW = DirW
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW:0]   rem_sh, diff;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    rem_sh = {rem_q, num_q[NumW-1]};
    diff   = rem_sh - {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = diff[DenW-1:0];
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DenW-1:0];
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire
